// ===== src/wrapping_log_ring_buffer_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Wrapping log ring buffer - assertion macros
// Concurrent check macros; they expand to nothing under synthesis.
// ---------------------------------------------------------------------------
`ifndef WRAPPING_LOG_RING_BUFFER_UNIT_ASSERT_SVH
`define WRAPPING_LOG_RING_BUFFER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define WLRB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wlrb check failed");

`define WLRB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wlrb check failed");

`else

`define WLRB_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`define WLRB_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/wlrb_pkg.sv =====
// ---------------------------------------------------------------------------
// Wrapping log ring buffer - package
// Sizes, command codes and the store request shared by the modules.
// ---------------------------------------------------------------------------
package wlrb_pkg;

  localparam int unsigned LogBytes = 4096;
  localparam int unsigned AddrW    = $clog2(LogBytes);
  localparam int unsigned CountW   = $clog2(LogBytes + 1);

  localparam logic [1:0] CmdAppend = 2'd0;
  localparam logic [1:0] CmdStart  = 2'd1;
  localparam logic [1:0] CmdRead   = 2'd2;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } store_req_t;

endpackage

// ===== src/wlrb_store.sv =====
// ---------------------------------------------------------------------------
// Wrapping log ring buffer - byte store
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module wlrb_store (
  input  logic                clk_i,
  input  wlrb_pkg::store_req_t req_i,
  output logic [7:0]          rdata_o
);

  logic [7:0] mem [wlrb_pkg::LogBytes];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/wlrb_ctrl.sv =====
// ---------------------------------------------------------------------------
// Wrapping log ring buffer - position control
// Write position, wrap flag, dump snapshot and the result register.
// ---------------------------------------------------------------------------
module wlrb_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic [1:0]                     command_i,
  input  logic [7:0]                     data_byte_i,
  input  logic [31:0]                    limit_i,
  input  logic                           out_take_i,
  output wlrb_pkg::store_req_t           req_o,
  output logic                           out_valid_o,
  output logic [wlrb_pkg::CountW-1:0]    dump_count_o,
  output logic                           byte_valid_o,
  output logic                           last_byte_o,
  output logic [wlrb_pkg::CountW-1:0]    remaining_o
);

  localparam int unsigned AddrW  = wlrb_pkg::AddrW;
  localparam int unsigned CountW = wlrb_pkg::CountW;
  localparam logic [AddrW-1:0]  LastPos  = AddrW'(wlrb_pkg::LogBytes - 1);
  localparam logic [CountW:0]   FullExt  = (CountW+1)'(wlrb_pkg::LogBytes);
  localparam logic [CountW-1:0] FullCnt  = CountW'(wlrb_pkg::LogBytes);

  logic [AddrW-1:0]  wpos_q, wpos_d;
  logic              wrapped_q, wrapped_d;
  logic [AddrW-1:0]  cursor_q, cursor_d;
  logic [CountW-1:0] rem_q, rem_d;
  logic              out_valid_q, out_valid_d;
  logic [CountW-1:0] count_q, count_d;
  logic              bvalid_q, bvalid_d;
  logic              last_q, last_d;

  logic [CountW-1:0] held;
  logic [CountW-1:0] clamp;
  logic [CountW:0]   wpos_ext;
  logic [CountW:0]   start_ext;
  logic [AddrW-1:0]  wpos_nxt;
  logic [AddrW-1:0]  cursor_nxt;

  assign held     = wrapped_q ? FullCnt : CountW'(wpos_q);
  assign clamp    = (limit_i < 32'(held)) ? limit_i[CountW-1:0] : held;
  assign wpos_ext = (CountW+1)'(wpos_q);
  assign start_ext = (wpos_ext >= (CountW+1)'(clamp)) ?
                     (wpos_ext - (CountW+1)'(clamp)) :
                     (wpos_ext + FullExt - (CountW+1)'(clamp));
  assign wpos_nxt   = (wpos_q == LastPos) ? '0 : wpos_q + 1'b1;
  assign cursor_nxt = (cursor_q == LastPos) ? '0 : cursor_q + 1'b1;

  always_comb begin
    wpos_d      = wpos_q;
    wrapped_d   = wrapped_q;
    cursor_d    = cursor_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q;
    count_d     = count_q;
    bvalid_d    = bvalid_q;
    last_d      = last_q;
    req_o.we    = 1'b0;
    req_o.waddr = wpos_q;
    req_o.wdata = data_byte_i;
    req_o.re    = 1'b0;
    req_o.raddr = cursor_q;
    if (out_take_i) begin
      out_valid_d = 1'b0;
    end
    if (accept_i) begin
      out_valid_d = 1'b1;
      count_d     = '0;
      bvalid_d    = 1'b0;
      last_d      = 1'b0;
      case (command_i)
        wlrb_pkg::CmdAppend: begin
          req_o.we = 1'b1;
          wpos_d   = wpos_nxt;
          if (wpos_nxt == '0) begin
            wrapped_d = 1'b1;
          end
        end
        wlrb_pkg::CmdStart: begin
          cursor_d = start_ext[AddrW-1:0];
          rem_d    = clamp;
          count_d  = clamp;
        end
        wlrb_pkg::CmdRead: begin
          if (rem_q != '0) begin
            req_o.re = 1'b1;
            bvalid_d = 1'b1;
            last_d   = (rem_q == CountW'(1));
            cursor_d = cursor_nxt;
            rem_d    = rem_q - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q      <= '0;
      wrapped_q   <= 1'b0;
      cursor_q    <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      bvalid_q    <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      wpos_q      <= wpos_d;
      wrapped_q   <= wrapped_d;
      cursor_q    <= cursor_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
      bvalid_q    <= bvalid_d;
      last_q      <= last_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign dump_count_o = count_q;
  assign byte_valid_o = bvalid_q;
  assign last_byte_o  = last_q;
  assign remaining_o  = rem_q;

endmodule

// ===== src/wrapping_log_ring_buffer_unit.sv =====
// ---------------------------------------------------------------------------
// Wrapping log ring buffer - top level
// Circular byte log with oldest-first dump readout.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser carries the command (append, start dump, read next),
//   tdata the byte to append and the dump limit. Every transaction gives
//   exactly one result transaction on the master stream: tdata carries the
//   dump count and the read byte, tuser marks a valid byte, tlast marks the
//   final byte of a dump.
//   The result appears in the cycle after acceptance; one transaction is
//   taken per cycle while results drain, since the store has one write and
//   one registered read port and a command touches at most one of them.
//   A read following an append in the next cycle sees the new byte, as the
//   write lands before the read is issued.
//   Reset clears positions, the wrap flag and the dump snapshot; store
//   contents are left as they are and are only read where written.
//   When the receiver stalls, the result is held and the slave side stops
//   accepting until it is taken.
// ---------------------------------------------------------------------------
`include "wrapping_log_ring_buffer_unit_assert.svh"

module wrapping_log_ring_buffer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // data_byte[7:0], limit[39:8]
  input  logic [1:0]  s_axis_tuser_i,  // command[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // dump_count[12:0], read_byte[20:13], zero[23:21]
  output logic [0:0]  m_axis_tuser_o,  // byte_valid[0]
  output logic        m_axis_tlast_o   // last_byte
);

  localparam int unsigned CountW = wlrb_pkg::CountW;

  wlrb_pkg::store_req_t req;
  logic [7:0]          rdata;
  logic                accept;
  logic                take;
  logic                out_valid;
  logic [CountW-1:0]   dump_count;
  logic                byte_valid;
  logic                last_byte;
  logic [CountW-1:0]   remaining;

  assign take            = m_axis_tvalid_o && m_axis_tready_i;
  assign s_axis_tready_o = !out_valid || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  wlrb_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .command_i    (s_axis_tuser_i),
    .data_byte_i  (s_axis_tdata_i[7:0]),
    .limit_i      (s_axis_tdata_i[39:8]),
    .out_take_i   (take),
    .req_o        (req),
    .out_valid_o  (out_valid),
    .dump_count_o (dump_count),
    .byte_valid_o (byte_valid),
    .last_byte_o  (last_byte),
    .remaining_o  (remaining)
  );

  wlrb_store u_store (
    .clk_i   (clk_i),
    .req_i   (req),
    .rdata_o (rdata)
  );

  assign m_axis_tvalid_o = out_valid;
  assign m_axis_tdata_o  = {3'b000, (byte_valid ? rdata : 8'h00), dump_count};
  assign m_axis_tuser_o  = byte_valid;
  assign m_axis_tlast_o  = last_byte;

  `WLRB_ASSERT_IMPL(a_last_has_byte, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tlast_o, m_axis_tuser_o[0])
  `WLRB_ASSERT_IMPL(a_rem_bound, clk_i, rst_ni, 1'b1, remaining <= CountW'(wlrb_pkg::LogBytes))
  `WLRB_ASSERT_NEXT(a_read_dec, clk_i, rst_ni, accept && (s_axis_tuser_i == wlrb_pkg::CmdRead) && (remaining != '0), (remaining == $past(remaining) - 1'b1) && m_axis_tvalid_o && m_axis_tuser_o[0])
  `WLRB_ASSERT_IMPL(a_one_port, clk_i, rst_ni, 1'b1, !(req.we && req.re))

endmodule
